>>> hdl/assert_macros.svh
// Assertion macros shared by the sieve RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pst_pkg.sv
// Package for the prime sieve table: sizes, codes and the structs
// passed between the build sequencer and the top level. No dependencies.
package pst_pkg;

  localparam int unsigned SIEVE_SIZE = 1048576;
  localparam int unsigned FIELD_W    = 20;
  localparam int unsigned ADDR_W     = $clog2(SIEVE_SIZE);
  localparam int unsigned CMP_W      = (ADDR_W > FIELD_W) ? ADDR_W : FIELD_W;
  localparam int unsigned CNT_W      = CMP_W + 1;

  localparam logic [CMP_W-1:0] MAX_NUM     = CMP_W'(SIEVE_SIZE - 1);
  localparam int unsigned      FIRST_PRIME = 2;

  typedef enum logic {
    OP_BUILD = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ANSWERED = 2'd0,
    ST_BUILT    = 2'd1,
    ST_BEYOND   = 2'd2,
    ST_UNBUILT  = 2'd3
  } status_e;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic              wdata;
  } pst_mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pst_bld_stat_t;

endpackage

>>> hdl/pst_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module pst_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/pst_build_seq.sv
// Build sequencer: fills the primality store, then crosses off multiples.
// Depends on pst_pkg; drives the store through a pst_mem_req_t.
module pst_build_seq
  import pst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CMP_W-1:0] limit_i,
  input  logic             rd_bit_i,
  input  logic             ack_i,
  output pst_bld_stat_t    stat_o,
  output pst_mem_req_t     req_o,
  output logic [CMP_W-1:0] limit_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_CHECK = 6'b001000,
    S_CROSS = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CMP_W-1:0] lim_q, lim_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] sq_q, sq_d;
  logic [CNT_W-1:0] lim_ext;
  logic [CNT_W-1:0] sq_next;

  assign lim_ext = CNT_W'(lim_q);
  // (i+1)^2 = i^2 + 2i + 1
  assign sq_next = sq_q + {i_q[CNT_W-2:0], 1'b0} + CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    lim_d      = lim_q;
    j_d        = j_q;
    i_d        = i_q;
    sq_d       = sq_q;
    req_o      = '0;
    req_o.addr = j_q[ADDR_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          lim_d   = limit_i;
          j_d     = '0;
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        // Entries 0 and 1 are always written, even for a limit below one.
        req_o.we    = 1'b1;
        req_o.wdata = (j_q >= CNT_W'(FIRST_PRIME));
        if ((j_q >= lim_ext) && (j_q >= CNT_W'(1))) begin
          i_d     = CNT_W'(FIRST_PRIME);
          sq_d    = CNT_W'(FIRST_PRIME * FIRST_PRIME);
          state_d = S_SCAN;
        end else begin
          j_d = j_q + CNT_W'(1);
        end
      end
      S_SCAN: begin
        req_o.addr = i_q[ADDR_W-1:0];
        if (sq_q > lim_ext) begin
          state_d = S_DONE;
        end else begin
          req_o.re = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rd_bit_i) begin
          j_d     = sq_q;
          state_d = S_CROSS;
        end else begin
          i_d     = i_q + CNT_W'(1);
          sq_d    = sq_next;
          state_d = S_SCAN;
        end
      end
      S_CROSS: begin
        if (j_q <= lim_ext) begin
          req_o.we    = 1'b1;
          req_o.wdata = 1'b0;
          j_d         = j_q + i_q;
        end else begin
          i_d     = i_q + CNT_W'(1);
          sq_d    = sq_next;
          state_d = S_SCAN;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= lim_d;
    j_q   <= j_d;
    i_q   <= i_d;
    sq_q  <= sq_d;
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign limit_o     = lim_q;

endmodule

>>> hdl/prime_sieve_table_unit.sv
// Top level of the prime sieve table: stream handshakes, limit register,
// query pipeline and result register. Uses pst_pkg, pst_ram, pst_build_seq.
//
// Channel   Direction  Accepted when                   Carries
// s_axis    in         s_axis_tvalid & s_axis_tready   tuser: operation, tdata: number
// m_axis    out        m_axis_tvalid & m_axis_tready   tuser: status,    tdata: prime
// cfg       in         cfg_valid_i & cfg_ready_o       cfg_data_i: sieve limit
//
// A query reads one bit of the store; its result goes from the registered RAM
// read in stage p to the result register, and queries follow one per cycle
// while the output does not stall, limited by the single RAM port. A build
// makes one store write or read per cycle; no input is taken meanwhile.
// Reset clears the control state only: the store is not swept.
// A stalled output holds its result and stops intake once the pipe is full.
`include "assert_macros.svh"

module prime_sieve_table_unit
  import pst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // [19:0] number, [23:20] zero
  input  logic               s_axis_tuser,  // [0] operation
  // Result stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [0] prime, [7:1] zero
  output logic [1:0]         m_axis_tuser,  // [1:0] status
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FIELD_W-1:0] cfg_data_i
);

  // Configuration and build bookkeeping.
  logic [FIELD_W-1:0] sieve_limit_q;
  logic               built_flag_q;
  logic [FIELD_W-1:0] built_limit_q;
  logic [CMP_W-1:0]   cfg_ext;
  logic [CMP_W-1:0]   eff_limit;

  // Query pipeline: stage p waits on the RAM read, stage out holds the result.
  logic    p_vld_q;
  logic    p_use_mem_q;
  status_e p_status_q;
  logic    p_adv;
  logic    out_vld_q;
  logic    out_prime_q;
  status_e out_status_q;

  logic          s_acc;
  logic          is_query;
  logic          q_re;
  logic          bld_start;
  logic          bld_ack;
  logic          rd_bit;
  logic [FIELD_W-1:0] number;
  logic [CMP_W-1:0]   num_ext;
  pst_bld_stat_t      bld_stat;
  pst_mem_req_t       bld_req;
  pst_mem_req_t       mem_req;
  logic [CMP_W-1:0]   bld_limit;
  status_e            q_status;

  assign cfg_ready_o = 1'b1;

  // A configured limit above the store saturates to its last entry.
  assign cfg_ext   = CMP_W'(sieve_limit_q);
  assign eff_limit = (cfg_ext > MAX_NUM) ? MAX_NUM : cfg_ext;

  // Stage p may move on whenever the result register is empty or draining.
  assign p_adv = p_vld_q && (!out_vld_q || m_axis_tready);

  // Intake runs while no build is in progress and stage p will be free.
  assign s_axis_tready = !bld_stat.busy && (!p_vld_q || p_adv);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign is_query      = (s_axis_tuser == OP_QUERY);
  assign number        = s_axis_tdata[FIELD_W-1:0];
  assign num_ext       = CMP_W'(number);

  assign bld_start = s_acc && !is_query;
  assign q_re      = s_acc && is_query;

  // The finished build takes stage p once it frees; p is empty at build start.
  assign bld_ack = bld_stat.done && (!p_vld_q || p_adv);

  always_comb begin
    if (!built_flag_q) begin
      q_status = ST_UNBUILT;
    end else if (number > built_limit_q) begin
      q_status = ST_BEYOND;
    end else begin
      q_status = ST_ANSWERED;
    end
  end

  // The sequencer owns the RAM port during a build; otherwise queries use it.
  always_comb begin
    if (bld_stat.busy) begin
      mem_req = bld_req;
    end else begin
      mem_req       = '0;
      mem_req.re    = q_re;
      mem_req.addr  = num_ext[ADDR_W-1:0];
    end
  end

  pst_ram #(
    .WIDTH (1),
    .DEPTH (SIEVE_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (mem_req.re),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rd_bit)
  );

  pst_build_seq u_build (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bld_start),
    .limit_i  (eff_limit),
    .rd_bit_i (rd_bit),
    .ack_i    (bld_ack),
    .stat_o   (bld_stat),
    .req_o    (bld_req),
    .limit_o  (bld_limit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sieve_limit_q <= {FIELD_W{1'b1}};
      built_flag_q  <= 1'b0;
      built_limit_q <= '0;
      p_vld_q       <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        sieve_limit_q <= cfg_data_i;
      end
      if (bld_ack) begin
        built_flag_q  <= 1'b1;
        built_limit_q <= FIELD_W'(bld_limit);
      end
      if (q_re || bld_ack) begin
        p_vld_q <= 1'b1;
      end else if (p_adv) begin
        p_vld_q <= 1'b0;
      end
      if (p_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (q_re) begin
      p_use_mem_q <= (q_status == ST_ANSWERED);
      p_status_q  <= q_status;
    end else if (bld_ack) begin
      p_use_mem_q <= 1'b0;
      p_status_q  <= ST_BUILT;
    end
    if (p_adv) begin
      out_prime_q  <= p_use_mem_q && rd_bit;
      out_status_q <= p_status_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_prime_q};
  assign m_axis_tuser  = out_status_q;

  `PST_ASSERT_NOW(a_port_excl, q_re, !bld_req.re && !bld_req.we,
                  "query read collides with a build access")
  `PST_ASSERT_NEXT(a_build_starts, bld_start, bld_stat.busy,
                   "build transaction did not start the sequencer")
  `PST_ASSERT_NOW(a_no_intake_busy, bld_stat.busy, !s_axis_tready,
                  "input taken while a build is in progress")
  `PST_ASSERT_NOW(a_p_free_at_ack, bld_ack, !p_vld_q || p_adv,
                  "build result overwrites a pending query")

endmodule
